// ===== src/dcplt_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the distributed-clock period trim block.
// Depends on nothing; the top level takes everything by scoped names.
package dcplt_pkg;

	// Register map of the configuration port.
	typedef enum logic [0:0] {
		REG_MAX_ADJUST = 1'b0,
		REG_INT_LIMIT  = 1'b1
	} cfg_reg_t;

	localparam int unsigned NUM_STAGES = 10;

	// Register reset values.
	localparam logic [16:0] MAX_ADJ_RST = 17'd2000;
	localparam logic [14:0] INT_LIM_RST = 15'd20000;

	// The 2 ms cycle is 128 * 15625 ns: the low seven bits pass straight through and
	// the rest is reduced modulo 15625 through residues of 14-bit chunks.
	localparam logic [13:0] RES_DIV  = 14'd15625;
	localparam logic [13:0] RES_W1   = 14'((64'd1 << 14) % 64'd15625);
	localparam logic [13:0] RES_W2   = 14'((64'(RES_W1) * 64'(RES_W1)) % 64'd15625);
	localparam logic [13:0] RES_W3   = 14'((64'(RES_W2) * 64'(RES_W1)) % 64'd15625);
	localparam logic [13:0] RES_WNEG = 14'((64'd15625
		- ((64'(RES_W3) * 64'(RES_W1)) % 64'd15625)) % 64'd15625);

	// Reciprocals for exact floor division of bounded magnitudes.
	localparam logic [30:0] RES_RECIP   = 31'(((64'd1 << 44) + 64'd15624) / 64'd15625);
	localparam logic [20:0] PROP_RECIP  = 21'(((64'd1 << 27) + 64'd99) / 64'd100);
	localparam logic [15:0] INT_RECIP   = 16'(((64'd1 << 20) + 64'd19) / 64'd20);
	localparam logic [15:0] SCALE_RECIP = 16'(((64'd1 << 18) + 64'd4) / 64'd5);

	localparam logic signed [21:0] HALF_CYCLE_NS = 22'sd1000000;
	localparam logic signed [21:0] CYCLE_NS      = 22'sd2000000;
	localparam logic [19:0]        NOMINAL_COUNTS = 20'd800000;

endpackage

// ===== src/dc_phase_lock_period_trim.sv =====
`timescale 1ns / 1ps
// Phase-lock trim of a 2 ms timer period from distributed-clock timestamps.
// Depends on dcplt_pkg for constants, reciprocals and the register map.
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   dc_time (64-bit signed ns)
// output    out        out_valid / out_ready timer_period (20-bit counts)
// config    in         cfg_we                cfg_index, cfg_data
//
// Each word passes through ten register stages before out_valid rises, and one
// word can enter every cycle unless out_ready holds the output. The depth is set by
// the modulo reduction (partial products, sum, reciprocal multiply, remainder)
// followed by the error, integrator, two constant divisions, clamp and scaling
// stages. Reset clears all valid bits, the lock flag, the target phase, the
// integrator and the registers to their defaults. Each stage holds while the one
// after it is full and stalled, so empty stages still fill and a new word is taken
// while a finished result waits on the output register.
module dc_phase_lock_period_trim (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [63:0] dc_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [19:0] timer_period,
	input  logic               cfg_we,
	input  logic         [0:0] cfg_index,
	input  logic        [16:0] cfg_data
);

	localparam int unsigned NS = dcplt_pkg::NUM_STAGES;

	// Configuration registers.
	logic [16:0] max_adj_q;
	logic [14:0] int_lim_q;

	// Loop state.
	logic               locked_q;
	logic        [20:0] target_q;
	logic signed [15:0] int_q;

	// Handshake: a stage may load when it is empty or its word moves on.
	logic [NS:1] vld_q;
	logic [NS:1] rdy;

	// Pipeline payload.
	logic        [63:0] time_s1;
	logic        [13:0] c0_s2;
	logic        [27:0] p1_s2, p2_s2, p3_s2;
	logic               neg_s2;
	logic        [6:0]  low_s2, low_s3, low_s4;
	logic        [28:0] sum_s3, sum_s4;
	logic        [15:0] quo_s4;
	logic        [20:0] phase_s5;
	logic signed [20:0] err_s6;
	logic signed [15:0] int_s7;
	logic signed [14:0] prop_s7, prop_s8;
	logic signed [11:0] iq_s8;
	logic signed [14:0] adj_s9;
	logic        [19:0] period_s10;

	// Combinational stage logic.
	logic        [27:0] p1, p2, p3;
	logic        [59:0] recip_prod;
	logic        [28:0] quo_scaled, rem_full;
	logic signed [21:0] diff, err_w;
	logic signed [16:0] step, int_sum, lim17, int_clamp;
	logic        [20:0] err_abs;
	logic        [40:0] prop_prod;
	logic        [13:0] pq;
	logic        [15:0] int_abs;
	logic        [30:0] int_prod;
	logic        [10:0] iq;
	logic signed [15:0] adj;
	logic signed [17:0] adj18, amax18, adj_clamp;
	logic        [14:0] adj_abs;
	logic        [30:0] sc_prod;
	logic        [12:0] sq;

	assign in_ready     = rdy[1];
	assign out_valid    = vld_q[NS];
	assign timer_period = period_s10;

	always_comb begin
		rdy[NS] = !vld_q[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	// Configuration writes; an index outside the map is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_adj_q <= dcplt_pkg::MAX_ADJ_RST;
			int_lim_q <= dcplt_pkg::INT_LIM_RST;
		end else if (cfg_we) begin
			case (dcplt_pkg::cfg_reg_t'(cfg_index))
				dcplt_pkg::REG_MAX_ADJUST: begin
					max_adj_q <= cfg_data;
				end
				dcplt_pkg::REG_INT_LIMIT: begin
					int_lim_q <= cfg_data[14:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Valid bits. The first word after reset only captures the target and is
	// dropped when it leaves the phase stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (rdy[k]) begin
					if (k == 6) begin
						vld_q[k] <= vld_q[k - 1] && locked_q;
					end else begin
						vld_q[k] <= vld_q[k - 1];
					end
				end
			end
		end
	end

	// Residue reduction. The upper 57 bits of the time are a floored quotient by
	// 128; its four 14-bit chunks and its sign are weighted by their residues.
	assign p1 = 28'(time_s1[34:21]) * 28'(dcplt_pkg::RES_W1);
	assign p2 = 28'(time_s1[48:35]) * 28'(dcplt_pkg::RES_W2);
	assign p3 = 28'(time_s1[62:49]) * 28'(dcplt_pkg::RES_W3);

	assign recip_prod = 60'(sum_s3) * 60'(dcplt_pkg::RES_RECIP);
	assign quo_scaled = 29'(quo_s4) * 29'(dcplt_pkg::RES_DIV);
	assign rem_full   = sum_s4 - quo_scaled;

	// Phase error against the target, wrapped to the shorter way round. An error
	// of exactly half a cycle keeps its sign.
	always_comb begin
		diff  = $signed({1'b0, phase_s5}) - $signed({1'b0, target_q});
		err_w = diff;
		if (diff > dcplt_pkg::HALF_CYCLE_NS) begin
			err_w = diff - dcplt_pkg::CYCLE_NS;
		end else if (diff < -dcplt_pkg::HALF_CYCLE_NS) begin
			err_w = diff + dcplt_pkg::CYCLE_NS;
		end
	end

	// Sign-counting integrator, clamped symmetrically after the step, and the
	// proportional term as a division by 100 truncated toward zero.
	always_comb begin
		if (err_s6 > 21'sd0) begin
			step = 17'sd1;
		end else if (err_s6 < 21'sd0) begin
			step = -17'sd1;
		end else begin
			step = 17'sd0;
		end
		int_sum = $signed({int_q[15], int_q}) + step;
		lim17   = $signed({2'b00, int_lim_q});
		if (int_sum > lim17) begin
			int_clamp = lim17;
		end else if (int_sum < -lim17) begin
			int_clamp = -lim17;
		end else begin
			int_clamp = int_sum;
		end
		err_abs   = err_s6[20] ? (~err_s6 + 21'd1) : err_s6;
		prop_prod = 41'(err_abs[19:0]) * 41'(dcplt_pkg::PROP_RECIP);
		pq        = prop_prod[40:27];
	end

	// Integral term as a division by 20 truncated toward zero.
	assign int_abs  = int_s7[15] ? (~int_s7 + 16'd1) : int_s7;
	assign int_prod = 31'(int_abs[14:0]) * 31'(dcplt_pkg::INT_RECIP);
	assign iq       = int_prod[30:20];

	// Correction and its clamp to the largest allowed adjustment.
	always_comb begin
		adj    = -$signed({prop_s8[14], prop_s8}) - $signed({{4{iq_s8[11]}}, iq_s8});
		adj18  = $signed({{2{adj[15]}}, adj});
		amax18 = $signed({1'b0, max_adj_q});
		if (adj18 > amax18) begin
			adj_clamp = amax18;
		end else if (adj18 < -amax18) begin
			adj_clamp = -amax18;
		end else begin
			adj_clamp = adj18;
		end
	end

	// Scale nanoseconds to counts by 2/5, truncated toward zero.
	assign adj_abs = adj_s9[14] ? (~adj_s9 + 15'd1) : adj_s9;
	assign sc_prod = 31'({adj_abs[13:0], 1'b0}) * 31'(dcplt_pkg::SCALE_RECIP);
	assign sq      = sc_prod[30:18];

	// Lock capture and integrator state move with the word that drives them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			target_q <= '0;
			int_q    <= '0;
		end else begin
			if (vld_q[5] && rdy[6] && !locked_q) begin
				locked_q <= 1'b1;
				target_q <= phase_s5;
				int_q    <= '0;
			end else if (vld_q[6] && rdy[7]) begin
				int_q <= int_clamp[15:0];
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			time_s1 <= dc_time;
		end
		if (rdy[2]) begin
			c0_s2  <= time_s1[20:7];
			p1_s2  <= p1;
			p2_s2  <= p2;
			p3_s2  <= p3;
			neg_s2 <= time_s1[63];
			low_s2 <= time_s1[6:0];
		end
		if (rdy[3]) begin
			sum_s3 <= 29'(c0_s2) + 29'(p1_s2) + 29'(p2_s2) + 29'(p3_s2)
				+ (neg_s2 ? 29'(dcplt_pkg::RES_WNEG) : 29'd0);
			low_s3 <= low_s2;
		end
		if (rdy[4]) begin
			quo_s4 <= recip_prod[59:44];
			sum_s4 <= sum_s3;
			low_s4 <= low_s3;
		end
		if (rdy[5]) begin
			phase_s5 <= {rem_full[13:0], low_s4};
		end
		if (rdy[6]) begin
			err_s6 <= err_w[20:0];
		end
		if (rdy[7]) begin
			int_s7  <= int_clamp[15:0];
			prop_s7 <= err_s6[20] ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
		end
		if (rdy[8]) begin
			iq_s8   <= int_s7[15] ? -$signed({1'b0, iq}) : $signed({1'b0, iq});
			prop_s8 <= prop_s7;
		end
		if (rdy[9]) begin
			adj_s9 <= adj_clamp[14:0];
		end
		if (rdy[10]) begin
			period_s10 <= adj_s9[14] ? (dcplt_pkg::NOMINAL_COUNTS - 20'(sq))
				: (dcplt_pkg::NOMINAL_COUNTS + 20'(sq));
		end
	end

endmodule
